// ===== sv/undirected_graph_edge_store_defines.svh =====
// assertion macros used by the bound checker module ugs_chk
`ifndef UNDIRECTED_GRAPH_EDGE_STORE_DEFINES_SVH
`define UNDIRECTED_GRAPH_EDGE_STORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UGS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ugs_pkg.sv =====
package ugs_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_DEGREE   = 16;
	localparam int VTX_W        = $clog2(MAX_VERTICES);
	localparam int LEN_W        = $clog2(MAX_DEGREE + 1);
	localparam int TBL_DEPTH    = MAX_VERTICES * MAX_DEGREE;
	localparam int TBL_AW       = $clog2(TBL_DEPTH);
	localparam int CNT_W        = 7;
	localparam int ACT_W        = 3;
	localparam int ST_W         = 3;
	localparam int IDX_W        = 10;

	localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_REM   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TEST  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_LIST  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_INDEX = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_ABSENT  = 3'd1;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_VTX = 3'd4;
	localparam logic [ST_W-1:0] ST_SELF    = 3'd5;

	typedef struct packed {
		logic             rd;
		logic             we;
		logic             clr;
		logic [VTX_W-1:0] addr;
		logic [LEN_W-1:0] wdata;
	} len_req_t;

	function automatic logic [TBL_AW-1:0] tbl_addr(input logic [VTX_W-1:0] row,
			input logic [LEN_W-1:0] col);
		return TBL_AW'(row * MAX_DEGREE) + TBL_AW'(col);
	endfunction

endpackage

// ===== sv/ugs_ram.sv =====
module ugs_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/ugs_len.sv =====
module ugs_len (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ugs_pkg::len_req_t          req,
	output logic [ugs_pkg::LEN_W-1:0]  rdata
);

	import ugs_pkg::*;

	logic [LEN_W-1:0]        mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] vld_q;
	logic [LEN_W-1:0]        rd_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd) begin
			rd_q <= mem[req.addr];
		end
	end

	// a row never written since the last clear reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

// ===== sv/ugs_seq.sv =====
module ugs_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ugs_pkg::ACT_W-1:0]   action,
	input  logic [ugs_pkg::VTX_W-1:0]   first_vertex,
	input  logic [ugs_pkg::VTX_W-1:0]   second_vertex,
	input  logic [ugs_pkg::IDX_W-1:0]   edge_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ugs_pkg::ST_W-1:0]    status,
	output logic                        edge_found,
	output logic                        item_valid,
	output logic [ugs_pkg::VTX_W-1:0]   low_end,
	output logic [ugs_pkg::VTX_W-1:0]   high_end,
	output logic                        last,
	input  logic                        cfg_wr_en,
	input  logic [ugs_pkg::CNT_W-1:0]   cfg_wr_data,
	output ugs_pkg::len_req_t           len_req,
	input  logic [ugs_pkg::LEN_W-1:0]   len_rdata,
	output logic                        tbl_we,
	output logic [ugs_pkg::TBL_AW-1:0]  tbl_waddr,
	output logic [ugs_pkg::VTX_W-1:0]   tbl_wdata,
	output logic                        tbl_re,
	output logic [ugs_pkg::TBL_AW-1:0]  tbl_raddr,
	input  logic [ugs_pkg::VTX_W-1:0]   tbl_rdata
);

	import ugs_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE  = 19'b1 << 0,
		S_LEN   = 19'b1 << 1,
		S_FIND  = 19'b1 << 2,
		S_FINDW = 19'b1 << 3,
		S_SHR   = 19'b1 << 4,
		S_SHW   = 19'b1 << 5,
		S_PUT   = 19'b1 << 6,
		S_RMR   = 19'b1 << 7,
		S_RMW   = 19'b1 << 8,
		S_LROW  = 19'b1 << 9,
		S_OLEN  = 19'b1 << 10,
		S_OWN   = 19'b1 << 11,
		S_OWNW  = 19'b1 << 12,
		S_LHIT  = 19'b1 << 13,
		S_LEND  = 19'b1 << 14,
		S_IXL   = 19'b1 << 15,
		S_IXW   = 19'b1 << 16,
		S_IXR   = 19'b1 << 17,
		S_FIN   = 19'b1 << 18
	} state_t;

	state_t            state_q, state_d;
	logic [ACT_W-1:0]  act_q, act_d;
	logic [VTX_W-1:0]  a_q, a_d;
	logic [CNT_W-1:0]  row_q, row_d;
	logic [VTX_W-1:0]  key_q, key_d;
	logic [LEN_W-1:0]  n_q, n_d;
	logic [LEN_W-1:0]  i_q, i_d;
	logic [LEN_W-1:0]  pos_q, pos_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic              own_q, own_d;
	logic              pend_v_q, pend_v_d;
	logic [VTX_W-1:0]  pend_q, pend_d;
	logic [VTX_W-1:0]  cand_q, cand_d;
	logic [ST_W-1:0]   res_st_q, res_st_d;
	logic              res_found_q, res_found_d;
	logic              res_valid_q, res_valid_d;
	logic [VTX_W-1:0]  res_lo_q, res_lo_d;
	logic [VTX_W-1:0]  res_hi_q, res_hi_d;
	logic [CNT_W-1:0]  vc_q;

	logic              out_valid_q;
	logic [ST_W-1:0]   out_st_q;
	logic              out_found_q, out_item_q, out_last_q;
	logic [VTX_W-1:0]  out_lo_q, out_hi_q;

	logic              out_load;
	logic [ST_W-1:0]   ld_st;
	logic              ld_found, ld_item, ld_last;
	logic [VTX_W-1:0]  ld_lo, ld_hi;

	logic              out_free;
	logic [CNT_W-1:0]  eff;
	logic [VTX_W-1:0]  lo_in, hi_in;
	logic              bad_pair;
	logic              find_done, have;
	logic [VTX_W-1:0]  row_v;

	assign out_free = !out_valid_q || !out_stall;
	assign eff      = (vc_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc_q;
	assign lo_in    = (first_vertex < second_vertex) ? first_vertex : second_vertex;
	assign hi_in    = (first_vertex < second_vertex) ? second_vertex : first_vertex;
	assign bad_pair = (CNT_W'(first_vertex) >= eff) || (CNT_W'(second_vertex) >= eff);
	assign row_v    = row_q[VTX_W-1:0];
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		act_d       = act_q;
		a_d         = a_q;
		row_d       = row_q;
		key_d       = key_q;
		n_d         = n_q;
		i_d         = i_q;
		pos_d       = pos_q;
		idx_d       = idx_q;
		own_d       = own_q;
		pend_v_d    = pend_v_q;
		pend_d      = pend_q;
		cand_d      = cand_q;
		res_st_d    = res_st_q;
		res_found_d = res_found_q;
		res_valid_d = res_valid_q;
		res_lo_d    = res_lo_q;
		res_hi_d    = res_hi_q;
		len_req     = '0;
		tbl_we      = 1'b0;
		tbl_waddr   = '0;
		tbl_wdata   = '0;
		tbl_re      = 1'b0;
		tbl_raddr   = '0;
		out_load    = 1'b0;
		ld_st       = ST_OK;
		ld_found    = 1'b0;
		ld_item     = 1'b0;
		ld_last     = 1'b0;
		ld_lo       = '0;
		ld_hi       = '0;
		find_done   = 1'b0;
		have        = 1'b0;

		len_req.clr = cfg_wr_en;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					act_d       = action;
					a_d         = first_vertex;
					idx_d       = edge_index;
					res_st_d    = ST_OK;
					res_found_d = 1'b0;
					res_valid_d = 1'b0;
					res_lo_d    = '0;
					res_hi_d    = '0;
					state_d     = S_FIN;
					unique case (action)
						ACT_ADD, ACT_REM, ACT_TEST: begin
							if (bad_pair) begin
								res_st_d = ST_BAD_VTX;
							end else if (first_vertex == second_vertex) begin
								res_st_d = ST_SELF;
							end else begin
								row_d        = CNT_W'(lo_in);
								key_d        = hi_in;
								len_req.rd   = 1'b1;
								len_req.addr = lo_in;
								state_d      = S_LEN;
							end
						end
						ACT_LIST: begin
							if (CNT_W'(first_vertex) >= eff) begin
								res_st_d = ST_BAD_VTX;
							end else begin
								row_d    = '0;
								key_d    = first_vertex;
								own_d    = 1'b0;
								pend_v_d = 1'b0;
								state_d  = S_LROW;
							end
						end
						ACT_INDEX: begin
							row_d   = '0;
							state_d = S_IXL;
						end
						ACT_CLEAR: begin
							len_req.clr = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_LEN: begin
				n_d     = len_rdata;
				i_d     = '0;
				state_d = S_FIND;
			end
			S_FIND: begin
				if (i_q >= n_q) begin
					find_done = 1'b1;
				end else begin
					tbl_re    = 1'b1;
					tbl_raddr = tbl_addr(row_v, i_q);
					state_d   = S_FINDW;
				end
			end
			S_FINDW: begin
				// the one shared compare: walk the sorted row until key or beyond
				if (tbl_rdata < key_q) begin
					i_d     = i_q + 1'b1;
					state_d = S_FIND;
				end else begin
					find_done = 1'b1;
					have      = (tbl_rdata == key_q);
				end
			end
			S_SHR: begin
				if (i_q == pos_q) begin
					state_d = S_PUT;
				end else begin
					tbl_re    = 1'b1;
					tbl_raddr = tbl_addr(row_v, i_q - 1'b1);
					state_d   = S_SHW;
				end
			end
			S_SHW: begin
				tbl_we    = 1'b1;
				tbl_waddr = tbl_addr(row_v, i_q);
				tbl_wdata = tbl_rdata;
				i_d       = i_q - 1'b1;
				state_d   = S_SHR;
			end
			S_PUT: begin
				tbl_we        = 1'b1;
				tbl_waddr     = tbl_addr(row_v, pos_q);
				tbl_wdata     = key_q;
				len_req.we    = 1'b1;
				len_req.addr  = row_v;
				len_req.wdata = n_q + 1'b1;
				state_d       = S_FIN;
			end
			S_RMR: begin
				if ({1'b0, i_q} + 1'b1 >= {1'b0, n_q}) begin
					len_req.we    = 1'b1;
					len_req.addr  = row_v;
					len_req.wdata = n_q - 1'b1;
					state_d       = S_FIN;
				end else begin
					tbl_re    = 1'b1;
					tbl_raddr = tbl_addr(row_v, i_q + 1'b1);
					state_d   = S_RMW;
				end
			end
			S_RMW: begin
				tbl_we    = 1'b1;
				tbl_waddr = tbl_addr(row_v, i_q);
				tbl_wdata = tbl_rdata;
				i_d       = i_q + 1'b1;
				state_d   = S_RMR;
			end
			S_LROW: begin
				len_req.rd = 1'b1;
				if (row_q < CNT_W'(a_q)) begin
					len_req.addr = row_v;
					state_d      = S_LEN;
				end else begin
					len_req.addr = a_q;
					own_d        = 1'b1;
					state_d      = S_OLEN;
				end
			end
			S_OLEN: begin
				n_d     = len_rdata;
				i_d     = '0;
				state_d = S_OWN;
			end
			S_OWN: begin
				if (i_q >= n_q) begin
					state_d = S_LEND;
				end else begin
					tbl_re    = 1'b1;
					tbl_raddr = tbl_addr(a_q, i_q);
					state_d   = S_OWNW;
				end
			end
			S_OWNW: begin
				cand_d  = tbl_rdata;
				i_d     = i_q + 1'b1;
				state_d = S_LHIT;
			end
			S_LHIT: begin
				// a neighbour goes out only once the next one shows it is not the last
				if (!pend_v_q || out_free) begin
					out_load = pend_v_q;
					ld_item  = 1'b1;
					ld_lo    = pend_q;
					pend_d   = cand_q;
					pend_v_d = 1'b1;
					if (own_q) begin
						state_d = S_OWN;
					end else begin
						row_d   = row_q + 1'b1;
						state_d = S_LROW;
					end
				end
			end
			S_LEND: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_item  = pend_v_q;
					ld_lo    = pend_v_q ? pend_q : '0;
					ld_last  = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_IXL: begin
				if (row_q >= eff) begin
					res_st_d = ST_ABSENT;
					state_d  = S_FIN;
				end else begin
					len_req.rd   = 1'b1;
					len_req.addr = row_v;
					state_d      = S_IXW;
				end
			end
			S_IXW: begin
				if (idx_q < IDX_W'(len_rdata)) begin
					tbl_re    = 1'b1;
					tbl_raddr = tbl_addr(row_v, idx_q[LEN_W-1:0]);
					state_d   = S_IXR;
				end else begin
					idx_d   = idx_q - IDX_W'(len_rdata);
					row_d   = row_q + 1'b1;
					state_d = S_IXL;
				end
			end
			S_IXR: begin
				res_valid_d = 1'b1;
				res_lo_d    = row_v;
				res_hi_d    = tbl_rdata;
				state_d     = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_st    = res_st_q;
					ld_found = res_found_q;
					ld_item  = res_valid_q;
					ld_lo    = res_lo_q;
					ld_hi    = res_hi_q;
					ld_last  = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (find_done) begin
			pos_d = (state_q == S_FIND) ? i_q : i_q;
			unique case (act_q)
				ACT_ADD: begin
					if (have) begin
						res_st_d = ST_PRESENT;
						state_d  = S_FIN;
					end else if (n_q >= LEN_W'(MAX_DEGREE)) begin
						res_st_d = ST_FULL;
						state_d  = S_FIN;
					end else begin
						i_d     = n_q;
						state_d = S_SHR;
					end
				end
				ACT_REM: begin
					if (!have) begin
						res_st_d = ST_ABSENT;
						state_d  = S_FIN;
					end else begin
						state_d = S_RMR;
					end
				end
				ACT_LIST: begin
					if (have) begin
						cand_d  = row_v;
						state_d = S_LHIT;
					end else begin
						row_d   = row_q + 1'b1;
						state_d = S_LROW;
					end
				end
				default: begin
					res_found_d = have;
					state_d     = S_FIN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vc_q        <= CNT_W'(MAX_VERTICES);
			pend_v_q    <= 1'b0;
			own_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pend_v_q <= pend_v_d;
			own_q    <= own_d;
			if (cfg_wr_en) begin
				vc_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		act_q       <= act_d;
		a_q         <= a_d;
		row_q       <= row_d;
		key_q       <= key_d;
		n_q         <= n_d;
		i_q         <= i_d;
		pos_q       <= pos_d;
		idx_q       <= idx_d;
		pend_q      <= pend_d;
		cand_q      <= cand_d;
		res_st_q    <= res_st_d;
		res_found_q <= res_found_d;
		res_valid_q <= res_valid_d;
		res_lo_q    <= res_lo_d;
		res_hi_q    <= res_hi_d;
		if (out_load) begin
			out_st_q    <= ld_st;
			out_found_q <= ld_found;
			out_item_q  <= ld_item;
			out_lo_q    <= ld_lo;
			out_hi_q    <= ld_hi;
			out_last_q  <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_st_q;
	assign edge_found = out_found_q;
	assign item_valid = out_item_q;
	assign low_end    = out_lo_q;
	assign high_end   = out_hi_q;
	assign last       = out_last_q;

endmodule

// ===== sv/undirected_graph_edge_store.sv =====
// Undirected graph store with sorted adjacency rows; one item is taken at a time and in_stall
// stays high until its work is done. Add, remove and test search the sorted row of the lower
// vertex, an add then shifts the later entries right and a remove shifts them left;
// a neighbour listing of vertex v searches rows 0..v-1 for v and then reads v's own row,
// and edge by index skips whole rows by their lengths. Row searches go through one
// compare, and all table accesses go through one table memory with registered reads. Results
// leave through an output register; a listing holds back each neighbour until the next one
// is found so the final one carries last.
module undirected_graph_edge_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ugs_pkg::ACT_W-1:0]  action,
	input  logic [ugs_pkg::VTX_W-1:0]  first_vertex,
	input  logic [ugs_pkg::VTX_W-1:0]  second_vertex,
	input  logic [ugs_pkg::IDX_W-1:0]  edge_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ugs_pkg::ST_W-1:0]   status,
	output logic                       edge_found,
	output logic                       item_valid,
	output logic [ugs_pkg::VTX_W-1:0]  low_end,
	output logic [ugs_pkg::VTX_W-1:0]  high_end,
	output logic                       last,
	input  logic                       cfg_wr_en,
	input  logic [ugs_pkg::CNT_W-1:0]  cfg_wr_data
);

	import ugs_pkg::*;

	len_req_t          len_req;
	logic [LEN_W-1:0]  len_rdata;
	logic              tbl_we, tbl_re;
	logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
	logic [VTX_W-1:0]  tbl_wdata, tbl_rdata;

	ugs_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.first_vertex  (first_vertex),
		.second_vertex (second_vertex),
		.edge_index    (edge_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.edge_found    (edge_found),
		.item_valid    (item_valid),
		.low_end       (low_end),
		.high_end      (high_end),
		.last          (last),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.len_req       (len_req),
		.len_rdata     (len_rdata),
		.tbl_we        (tbl_we),
		.tbl_waddr     (tbl_waddr),
		.tbl_wdata     (tbl_wdata),
		.tbl_re        (tbl_re),
		.tbl_raddr     (tbl_raddr),
		.tbl_rdata     (tbl_rdata)
	);

	ugs_len u_len (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (len_req),
		.rdata  (len_rdata)
	);

	ugs_ram #(
		.DEPTH (TBL_DEPTH),
		.WIDTH (VTX_W)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

endmodule

// ===== sv/ugs_chk.sv =====
`include "undirected_graph_edge_store_defines.svh"

module ugs_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [ugs_pkg::ST_W-1:0]   status,
	input logic                       edge_found,
	input logic                       item_valid,
	input logic [ugs_pkg::VTX_W-1:0]  low_end,
	input logic [ugs_pkg::VTX_W-1:0]  high_end,
	input logic                       last
);

	import ugs_pkg::*;

	`UGS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(low_end) && $stable(last), "stalled result changed")
	`UGS_ASSERT_IMP(a_empty_zero, out_valid && !item_valid, low_end == '0 && high_end == '0, "empty result carries a vertex")
	`UGS_ASSERT_IMP(a_err_single, out_valid && status != ST_OK, last && !item_valid && !edge_found, "error result not a lone final transfer")
	`UGS_ASSERT_IMP(a_found_plain, out_valid && edge_found, last && !item_valid && status == ST_OK, "test result malformed")

endmodule

bind undirected_graph_edge_store ugs_chk u_chk (.*);

// ===== bench/ugs_checker.sv =====
`timescale 1ns / 100ps

module ugs_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [ugs_pkg::ACT_W-1:0]  action,
	input  logic [ugs_pkg::VTX_W-1:0]  first_vertex,
	input  logic [ugs_pkg::VTX_W-1:0]  second_vertex,
	input  logic [ugs_pkg::IDX_W-1:0]  edge_index,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [ugs_pkg::ST_W-1:0]   status,
	input  logic                       edge_found,
	input  logic                       item_valid,
	input  logic [ugs_pkg::VTX_W-1:0]  low_end,
	input  logic [ugs_pkg::VTX_W-1:0]  high_end,
	input  logic                       last,
	input  logic                       cfg_wr_en,
	input  logic [ugs_pkg::CNT_W-1:0]  cfg_wr_data,
	output int                         fail_count,
	output int                         pending_results
);
	import ugs_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             found;
		logic             valid;
		logic [VTX_W-1:0] lo;
		logic [VTX_W-1:0] hi;
		logic             last;
	} graph_result_t;

	graph_result_t expected_results[$];
	logic [VTX_W-1:0] rows[MAX_VERTICES][MAX_DEGREE];
	int row_len[MAX_VERTICES];
	int live_count;

	assign pending_results = expected_results.size();

	function automatic graph_result_t mk(logic [ST_W-1:0] st, int f, int v,
			int lo, int hi, int l);
		graph_result_t r;
		r.status = st; r.found = f[0]; r.valid = v[0];
		r.lo = VTX_W'(lo); r.hi = VTX_W'(hi); r.last = l[0];
		return r;
	endfunction

	function automatic void queue_result(graph_result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic bit row_has(int row, int value, output int pos);
		int i;
		i = 0;
		while (i < row_len[row] && rows[row][i] < value) i++;
		pos = i;
		return i < row_len[row] && rows[row][i] == value;
	endfunction

	task automatic predict_graph_op(logic [ACT_W-1:0] act, int a, int b, int idx);
		int lo, hi, pos, k, r, i;
		bit have;
		graph_result_t buffer[$];
		lo = a < b ? a : b;
		hi = a < b ? b : a;
		if (act == ACT_ADD || act == ACT_REM || act == ACT_TEST) begin
			if (a >= live_count || b >= live_count)
				queue_result(mk(ST_BAD_VTX, 0, 0, 0, 0, 1));
			else if (a == b)
				queue_result(mk(ST_SELF, 0, 0, 0, 0, 1));
			else begin
				have = row_has(lo, hi, pos);
				if (act == ACT_ADD) begin
					if (have) queue_result(mk(ST_PRESENT, 0, 0, 0, 0, 1));
					else if (row_len[lo] >= MAX_DEGREE)
						queue_result(mk(ST_FULL, 0, 0, 0, 0, 1));
					else begin
						for (i = row_len[lo]; i > pos; i--) rows[lo][i] = rows[lo][i-1];
						rows[lo][pos] = VTX_W'(hi);
						row_len[lo]++;
						queue_result(mk(ST_OK, 0, 0, 0, 0, 1));
					end
				end else if (act == ACT_REM) begin
					if (!have) queue_result(mk(ST_ABSENT, 0, 0, 0, 0, 1));
					else begin
						for (i = pos; i + 1 < row_len[lo]; i++) rows[lo][i] = rows[lo][i+1];
						row_len[lo]--;
						queue_result(mk(ST_OK, 0, 0, 0, 0, 1));
					end
				end else
					queue_result(mk(ST_OK, have, 0, 0, 0, 1));
			end
		end else if (act == ACT_LIST) begin
			if (a >= live_count)
				queue_result(mk(ST_BAD_VTX, 0, 0, 0, 0, 1));
			else begin
				for (r = 0; r < a && buffer.size() < 63; r++)
					if (row_has(r, a, pos))
						buffer.insert(buffer.size(), mk(ST_OK, 0, 1, r, 0, 0));
				for (i = 0; i < row_len[a] && buffer.size() < 63; i++)
					buffer.insert(buffer.size(), mk(ST_OK, 0, 1, rows[a][i], 0, 0));
				if (buffer.size() == 0)
					buffer.insert(buffer.size(), mk(ST_OK, 0, 0, 0, 0, 1));
				buffer[buffer.size()-1].last = 1'b1;
				foreach (buffer[j]) queue_result(buffer[j]);
			end
		end else if (act == ACT_INDEX) begin
			k = idx;
			for (r = 0; r < live_count; r++) begin
				if (k < row_len[r]) begin
					queue_result(mk(ST_OK, 0, 1, r, rows[r][k], 1));
					return;
				end
				k -= row_len[r];
			end
			queue_result(mk(ST_ABSENT, 0, 0, 0, 0, 1));
		end else begin
			if (act == ACT_CLEAR) foreach (row_len[j]) row_len[j] = 0;
			queue_result(mk(ST_OK, 0, 0, 0, 0, 1));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		graph_result_t want;
		if (!arst_n) begin
			foreach (row_len[j]) row_len[j] = 0;
			live_count = MAX_VERTICES;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en) begin
				live_count = cfg_wr_data > MAX_VERTICES ? MAX_VERTICES : cfg_wr_data;
				foreach (row_len[j]) row_len[j] = 0;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, status);
						fail_count++;
					end
					if (edge_found !== want.found) begin
						$error("edge_found expected %0d actual %0d", want.found, edge_found);
						fail_count++;
					end
					if (item_valid !== want.valid) begin
						$error("item_valid expected %0d actual %0d", want.valid, item_valid);
						fail_count++;
					end
					if (low_end !== want.lo) begin
						$error("low_end expected %0d actual %0d", want.lo, low_end);
						fail_count++;
					end
					if (high_end !== want.hi) begin
						$error("high_end expected %0d actual %0d", want.hi, high_end);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last expected %0d actual %0d", want.last, last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_graph_op(action, first_vertex, second_vertex, edge_index);
		end
	end
endmodule

// ===== bench/tb_undirected_graph_edge_store.sv =====
`timescale 1ns / 100ps

module tb_undirected_graph_edge_store;
	import ugs_pkg::*;

	// action codes with no operation behind them
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_wr_en = 0;
	logic in_stall, out_valid, edge_found, item_valid, last;
	logic [ACT_W-1:0] action = ACT_ADD;
	logic [VTX_W-1:0] first_vertex = 0, second_vertex = 0, low_end, high_end;
	logic [IDX_W-1:0] edge_index = 0;
	logic [ST_W-1:0] status;
	logic [CNT_W-1:0] cfg_wr_data = 0;
	int fail_count, pending_results;
	int cycle_count = 0;
	int vtx_span = 64;
	int stall_left = 0;
	bit quiet_phase = 0;

	localparam int CYCLE_LIMIT = 20_000_000;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	undirected_graph_edge_store u_top (.*);
	ugs_checker u_chk (.*);

	function automatic int gap_len();
		if (quiet_phase) return 0;
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1;
			end else begin
				stall_left <= gap_len();
				out_stall <= 0;
			end
		end
	end

	// valid stays up into the next item when there is no gap
	task automatic send_op(logic [ACT_W-1:0] act, int a, int b, int idx);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		action <= act;
		first_vertex <= VTX_W'(a);
		second_vertex <= VTX_W'(b);
		edge_index <= IDX_W'(idx);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	task automatic write_count(int value);
		drain();
		cfg_wr_data <= CNT_W'(value);
		cfg_wr_en <= 1;
		@(posedge clk);
		cfg_wr_en <= 0;
		vtx_span = value == 0 ? 1 : (value > 64 ? 64 : value);
	endtask

	// mostly valid vertices in range, sometimes anything
	function automatic int pick_vtx();
		if ($urandom_range(0, 19) == 0) return $urandom_range(0, 63);
		return $urandom_range(0, vtx_span - 1);
	endfunction

	task automatic random_ops(int n);
		int r, a;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			a = pick_vtx();
			if (r < 40) send_op(ACT_ADD, a, pick_vtx(), $urandom);
			else if (r < 55) send_op(ACT_REM, a, pick_vtx(), $urandom);
			else if (r < 70) send_op(ACT_TEST, a, pick_vtx(), $urandom);
			else if (r < 82) send_op(ACT_LIST, a, $urandom, $urandom);
			else if (r < 94)
				send_op(ACT_INDEX, $urandom, $urandom,
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 80));
			else if (r < 96) send_op(ACT_CLEAR, $urandom, $urandom, $urandom);
			else send_op(ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
				$urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: fill a row past capacity, duplicates, faults, listing order
		quiet_phase = 1;
		for (int i = 1; i <= 17; i++) send_op(ACT_ADD, 0, 64 - i, 0);
		quiet_phase = 0;
		send_op(ACT_ADD, 63, 0, 0);
		send_op(ACT_ADD, 5, 5, 0);
		send_op(ACT_REM, 0, 1, 0);
		send_op(ACT_REM, 63, 0, 0);
		send_op(ACT_TEST, 0, 62, 0);
		send_op(ACT_TEST, 1, 2, 0);
		send_op(ACT_LIST, 62, 0, 0);
		send_op(ACT_LIST, 0, 0, 0);
		send_op(ACT_LIST, 1, 0, 0);
		send_op(ACT_INDEX, 0, 0, 14);
		send_op(ACT_INDEX, 0, 0, 1023);
		send_op(ACT_SPARE_LO, 63, 63, 1023);
		send_op(ACT_SPARE_HI, 0, 0, 0);
		send_op(ACT_CLEAR, 0, 0, 0);
		write_count(3);
		send_op(ACT_ADD, 2, 3, 0);
		send_op(ACT_LIST, 3, 0, 0);
		random_ops(30);
		write_count(0);
		send_op(ACT_ADD, 0, 1, 0);
		send_op(ACT_LIST, 0, 0, 0);
		write_count(127);
		random_ops(120);
		write_count(1);
		random_ops(10);
		write_count(8);
		random_ops(120);
		write_count(64);
		random_ops(110);
		drain();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
